FILE: sv/assert_macros.svh
// Assertion macros shared by the checker module of this block.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold in the next clock.
`define CHK_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

// When the trigger holds, the consequence must hold in the same clock.
`define CHK_SAME(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/iold_pkg.sv
// Shared widths, types, register indexes and reset values of the IMU filter block.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package iold_pkg;

   localparam int AXES       = 6;
   localparam int GYRO_FIRST = 3;
   localparam int AXIS_IDX_W = 3;

   localparam int SAMPLE_W = 32;
   localparam int X_W      = SAMPLE_W + 1;
   localparam int MEM_W    = SAMPLE_W + 2;
   localparam int D_W      = SAMPLE_W + 3;
   localparam int FRAC_W   = 16;
   localparam int OUT_W    = 16;
   localparam int OUT_MAX  = 32767;
   localparam int OUT_MIN  = -32768;

   localparam int WEIGHT_W  = 16;
   localparam int DIGIT_W   = 4;
   localparam int DIGITS    = WEIGHT_W / DIGIT_W;
   localparam int DIG_CNT_W = $clog2(DIGITS);
   localparam int PP_W      = D_W + DIGIT_W + 1;
   localparam int ACC_W     = D_W + WEIGHT_W;
   localparam int SCALE     = 1000;

   localparam int DEC_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEM_W-1:0]    mem_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [OUT_W-1:0]    out_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;

   localparam csr_idx_type REG_ACCEL_OFF_X = 3'd0;
   localparam csr_idx_type REG_ACCEL_OFF_Y = 3'd1;
   localparam csr_idx_type REG_ACCEL_OFF_Z = 3'd2;
   localparam csr_idx_type REG_GYRO_OFF_X  = 3'd3;
   localparam csr_idx_type REG_GYRO_OFF_Y  = 3'd4;
   localparam csr_idx_type REG_GYRO_OFF_Z  = 3'd5;
   localparam csr_idx_type REG_WEIGHT      = 3'd6;
   localparam csr_idx_type REG_DECIM       = 3'd7;

   localparam sample_type OFFSET_RESET [AXES] = '{
      32'sd44091, 32'sd39343, -32'sd122834, 32'sd1638, -32'sd4129, 32'sd524
   };
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd43647;
   localparam logic [DEC_W-1:0]    DECIM_RESET  = 8'd25;

endpackage

FILE: sv/imu_offset_lowpass_decimator.sv
// Top level of the IMU offset removal, low-pass and decimation block.
// Depends on iold_pkg for widths, types, register indexes and reset values.
`timescale 1ns / 1ps

// Each accepted item is one six-axis sample in signed Q16.16. The block removes
// the per-axis offset (gyro axes are also negated), runs every axis through the
// first-order low-pass y = x - floor(w * (x - y_prev) / 2^16) and, on every Nth
// item, returns all six filtered values times 1000, truncated toward zero and
// saturated to 16 bits. Axes at or beyond CHANNELS are not filtered and read 0.
// An item holds the block while min(CHANNELS, 6) axes are worked in turn, plus
// the wait state that hands the result to the output register when it produces
// a result, for as long as the result before it still waits unaccepted there. The
// time is set by the single digit-serial multiplier, which takes four 4-bit
// digits per pass and makes two passes per axis (the weight product, then the
// scaling by 1000), with the axes handled one after another. The input side is
// ready again while a finished result still waits on the output register. The
// filter memory is in flip-flops cleared directly by reset, so no clearing pass
// is needed. Configuration registers take effect at once and the write port is
// always ready outside reset; neither input port is ready during reset.

module imu_offset_lowpass_decimator #(
   parameter int CHANNELS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_accel_x,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_accel_z,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_rate_x,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_rate_y,
   input  logic signed [iold_pkg::SAMPLE_W-1:0] req_rate_z,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_accel_x,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_accel_y,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_accel_z,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_rate_x,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_rate_y,
   output logic signed [iold_pkg::OUT_W-1:0]    rsp_filt_rate_z,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iold_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iold_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Only the first six axes exist in a sample; channels beyond them are unused.
   localparam int ACT  = (CHANNELS < iold_pkg::AXES) ? CHANNELS : iold_pkg::AXES;
   localparam int CH_W = (ACT > 1) ? $clog2(ACT) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(ACT - 1);

   localparam int YF_W = iold_pkg::D_W + 1;
   localparam int Q_W  = iold_pkg::ACC_W - iold_pkg::FRAC_W;
   localparam logic [iold_pkg::DIG_CNT_W-1:0] DIG_LAST =
      iold_pkg::DIG_CNT_W'(iold_pkg::DIGITS - 1);
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(iold_pkg::OUT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(iold_pkg::OUT_MIN);
   localparam iold_pkg::acc_type FRAC_MASK =
      iold_pkg::ACC_W'(2 ** iold_pkg::FRAC_W - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_XSUB = 3'd1;
   localparam logic [2:0] ST_DSUB = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_YUPD = 3'd4;
   localparam logic [2:0] ST_OUTS = 3'd5;
   localparam logic [2:0] ST_WAIT = 3'd6;

   // Control state.
   logic [2:0]                          state_ff, state_in;
   logic [CH_W-1:0]                     ch_ff, ch_in;
   logic [iold_pkg::DIG_CNT_W-1:0]      dig_ff, dig_in;
   logic                                pass_ff, pass_in;
   logic [iold_pkg::DEC_W-1:0]          cnt_ff, cnt_in;
   logic                                emit_ff, emit_in;
   logic                                rsp_valid_ff;

   // Configuration registers.
   iold_pkg::sample_type                off_ff [iold_pkg::AXES];
   logic [iold_pkg::WEIGHT_W-1:0]       weight_ff;
   logic [iold_pkg::DEC_W-1:0]          decim_ff;

   // Datapath.
   iold_pkg::sample_type                req_smp [iold_pkg::AXES];
   iold_pkg::sample_type                smp_ff [ACT];
   iold_pkg::mem_type                   mem_ff [ACT];
   iold_pkg::out_type                   res_ff [iold_pkg::AXES];
   iold_pkg::out_type                   rsp_ff [iold_pkg::AXES];
   logic signed [iold_pkg::X_W-1:0]     x_ff, x_in;
   logic signed [iold_pkg::D_W-1:0]     mcand_ff, mcand_in;
   logic [iold_pkg::WEIGHT_W-1:0]       mplier_ff, mplier_in;
   iold_pkg::acc_type                   acc_ff, acc_in;

   logic                                smp_load, smp_shift, mem_we, res_we, rsp_load;
   logic [iold_pkg::AXIS_IDX_W-1:0]     axis;
   logic                                is_gyro;
   logic [iold_pkg::DEC_W-1:0]          cnt_inc;
   logic                                emit_now;
   logic signed [iold_pkg::X_W-1:0]     smp_x, off_x, x_calc;
   logic signed [iold_pkg::D_W-1:0]     d_calc;
   logic [iold_pkg::DIGIT_W-1:0]        digit;
   logic signed [iold_pkg::PP_W-1:0]    pp;
   iold_pkg::acc_type                   acc_step;
   logic signed [YF_W-1:0]              y_full;
   iold_pkg::mem_type                   y_calc;
   iold_pkg::acc_type                   trunc_sum;
   logic signed [Q_W-1:0]               q;
   iold_pkg::out_type                   sat;

   assign req_smp[0] = req_accel_x;
   assign req_smp[1] = req_accel_y;
   assign req_smp[2] = req_accel_z;
   assign req_smp[3] = req_rate_x;
   assign req_smp[4] = req_rate_y;
   assign req_smp[5] = req_rate_z;

   assign axis    = iold_pkg::AXIS_IDX_W'(ch_ff);
   assign is_gyro = (int'(ch_ff) >= iold_pkg::GYRO_FIRST);

   // Decimation: the counter advances on every item and returns to 0 when a result is due.
   assign cnt_inc  = cnt_ff + iold_pkg::DEC_W'(1);
   assign emit_now = (cnt_inc >= decim_ff);

   // Offset removal; the gyro axes come out negated.
   assign smp_x  = iold_pkg::X_W'(smp_ff[0]);
   assign off_x  = iold_pkg::X_W'(off_ff[axis]);
   assign x_calc = is_gyro ? (off_x - smp_x) : (smp_x - off_x);

   assign d_calc = iold_pkg::D_W'(x_ff) - iold_pkg::D_W'(mem_ff[ch_ff]);

   // One 4-bit digit of the multiplier per cycle, most significant digit first.
   // The product is a signed 35-bit value by an unsigned 4-bit digit.
   assign digit    = mplier_ff[iold_pkg::WEIGHT_W-1 -: iold_pkg::DIGIT_W];
   assign pp       = iold_pkg::PP_W'(mcand_ff) *
                     iold_pkg::PP_W'($signed({1'b0, digit}));
   assign acc_step = (acc_ff <<< iold_pkg::DIGIT_W) + iold_pkg::ACC_W'(pp);

   // The arithmetic shift floors the weighted difference; the new output lies
   // between x and the old output, so it always fits the 34-bit memory.
   assign y_full = YF_W'(x_ff) - YF_W'($signed(acc_ff[iold_pkg::ACC_W-1:iold_pkg::FRAC_W]));
   assign y_calc = $signed(y_full[iold_pkg::MEM_W-1:0]);

   // Scaled value divided by 2^16 toward zero: negative values get the
   // fraction mask added before the shift. Then saturate to 16 bits.
   assign trunc_sum = acc_ff + (acc_ff[iold_pkg::ACC_W-1] ? FRAC_MASK : '0);
   assign q         = $signed(trunc_sum[iold_pkg::ACC_W-1:iold_pkg::FRAC_W]);
   assign sat       = (q > Q_MAX) ? iold_pkg::OUT_W'(iold_pkg::OUT_MAX) :
                      (q < Q_MIN) ? iold_pkg::OUT_W'(iold_pkg::OUT_MIN) :
                      q[iold_pkg::OUT_W-1:0];

   // Sequencer: accept an item; per axis, offset removal, difference, weight product,
   // memory update, scale product, truncation and saturation; then the result hand-off.
   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      dig_in    = dig_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      emit_in   = emit_ff;
      x_in      = x_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      smp_load  = 1'b0;
      smp_shift = 1'b0;
      mem_we    = 1'b0;
      res_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_load = 1'b1;
               ch_in    = '0;
               emit_in  = emit_now;
               cnt_in   = emit_now ? '0 : cnt_inc;
               state_in = ST_XSUB;
            end
         end
         ST_XSUB: begin
            x_in     = x_calc;
            state_in = ST_DSUB;
         end
         ST_DSUB: begin
            mcand_in  = d_calc;
            mplier_in = weight_ff;
            acc_in    = '0;
            dig_in    = '0;
            pass_in   = 1'b0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            acc_in    = acc_step;
            mplier_in = mplier_ff << iold_pkg::DIGIT_W;
            dig_in    = dig_ff + iold_pkg::DIG_CNT_W'(1);
            if (dig_ff == DIG_LAST) begin
               state_in = pass_ff ? ST_OUTS : ST_YUPD;
            end
         end
         ST_YUPD: begin
            mem_we    = 1'b1;
            mcand_in  = iold_pkg::D_W'(y_calc);
            mplier_in = iold_pkg::WEIGHT_W'(iold_pkg::SCALE);
            acc_in    = '0;
            dig_in    = '0;
            pass_in   = 1'b1;
            state_in  = ST_MUL;
         end
         ST_OUTS: begin
            res_we = 1'b1;
            if (ch_ff == LAST_CH) begin
               state_in = emit_ff ? ST_WAIT : ST_IDLE;
            end else begin
               ch_in     = ch_ff + CH_W'(1);
               smp_shift = 1'b1;
               state_in  = ST_XSUB;
            end
         end
         ST_WAIT: begin
            // The result moves out once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control, configuration and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         dig_ff       <= '0;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= iold_pkg::WEIGHT_RESET;
         decim_ff     <= iold_pkg::DECIM_RESET;
         for (int c = 0; c < iold_pkg::AXES; c++) begin
            off_ff[c] <= iold_pkg::OFFSET_RESET[c];
            res_ff[c] <= '0;
         end
         for (int c = 0; c < ACT; c++) begin
            mem_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         dig_ff   <= dig_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we) begin
            mem_ff[ch_ff] <= y_calc;
         end
         if (res_we) begin
            res_ff[axis] <= sat;
         end
         if (csr_valid) begin
            unique case (csr_index) inside
               iold_pkg::REG_ACCEL_OFF_X, iold_pkg::REG_ACCEL_OFF_Y,
               iold_pkg::REG_ACCEL_OFF_Z, iold_pkg::REG_GYRO_OFF_X,
               iold_pkg::REG_GYRO_OFF_Y, iold_pkg::REG_GYRO_OFF_Z: begin
                  off_ff[csr_index] <= $signed(csr_wdata);
               end
               iold_pkg::REG_WEIGHT: begin
                  weight_ff <= csr_wdata[iold_pkg::WEIGHT_W-1:0];
               end
               iold_pkg::REG_DECIM: begin
                  decim_ff <= csr_wdata[iold_pkg::DEC_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers; the sample register shifts one axis down per axis done.
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      if (smp_load) begin
         for (int c = 0; c < ACT; c++) begin
            smp_ff[c] <= req_smp[c];
         end
      end else if (smp_shift) begin
         for (int c = 0; c < ACT - 1; c++) begin
            smp_ff[c] <= smp_ff[c + 1];
         end
      end
      if (rsp_load) begin
         for (int c = 0; c < iold_pkg::AXES; c++) begin
            rsp_ff[c] <= res_ff[c];
         end
      end
   end

   // Neither input port takes anything while reset is held.
   assign req_ready        = (state_ff == ST_IDLE) && !reset;
   assign csr_ready        = !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filt_accel_x = rsp_ff[0];
   assign rsp_filt_accel_y = rsp_ff[1];
   assign rsp_filt_accel_z = rsp_ff[2];
   assign rsp_filt_rate_x  = rsp_ff[3];
   assign rsp_filt_rate_y  = rsp_ff[4];
   assign rsp_filt_rate_z  = rsp_ff[5];

endmodule

FILE: sv/iold_checker.sv
// Port-level checker for the IMU filter block, bound to its top level.
// Depends on iold_pkg for widths and on assert_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iold_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_accel_x,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_accel_y,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_accel_z,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_rate_x,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_rate_y,
   input logic signed [iold_pkg::OUT_W-1:0] rsp_filt_rate_z
);

   // All six result fields side by side, so that one check covers them.
   logic [iold_pkg::AXES*iold_pkg::OUT_W-1:0] rsp_all;

   assign rsp_all = {rsp_filt_rate_z, rsp_filt_rate_y, rsp_filt_rate_x,
                     rsp_filt_accel_z, rsp_filt_accel_y, rsp_filt_accel_x};

   // An accepted item keeps the block busy in the following cycle.
   `CHK_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // Even one axis keeps the block at work through its whole sequence, so the input stays closed.
   `CHK_NEXT(a_busy_one_axis, req_valid && req_ready, ##11 !req_ready, "item finished too early")

   // A new result only appears out of work on an item.
   `CHK_SAME(a_result_from_work, $rose(rsp_valid), $past(!req_ready), "result while idle")

   // A stalled result holds its value.
   `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_all), "result moved")

endmodule

bind imu_offset_lowpass_decimator iold_checker u_iold_checker (.*);
